FILE: sv/pcm_to_16bit_sample_converter_core_assert.svh
// Assertion macros shared by the converter modules.
// PCM_ASSERT checks a property at every rising clock edge outside reset.
// PCM_ASSERT_IMPL checks that a condition implies a consequence in the next cycle.
`ifndef PCM_TO_16BIT_SAMPLE_CONVERTER_CORE_ASSERT_SVH
`define PCM_TO_16BIT_SAMPLE_CONVERTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PCM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define PCM_ASSERT_IMPL(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`else

`define PCM_ASSERT(lbl, clk, rstn, prop, msg)

`define PCM_ASSERT_IMPL(lbl, clk, rstn, cond, cons, msg)

`endif

`endif

FILE: sv/pcm16_pkg.sv
package pcm16_pkg;

    // Configuration register indexes.
    localparam logic CFG_BYTES_PER_SAMPLE = 1'b0;
    localparam logic CFG_CHANNEL_COUNT    = 1'b1;

    // Sample width codes.
    localparam logic [1:0] BPS_NONE = 2'd0;
    localparam logic [1:0] BPS_8    = 2'd1;
    localparam logic [1:0] BPS_16   = 2'd2;
    localparam logic [1:0] BPS_24   = 2'd3;

    // Channel code that selects stereo; every other code is mono.
    localparam logic [1:0] CHAN_STEREO = 2'd2;

    // Register values after reset.
    localparam logic [1:0] BPS_RESET  = BPS_16;
    localparam logic [1:0] CHAN_RESET = 2'd1;

    // One accepted input byte.
    typedef struct packed {
        logic       stream_start;
        logic [7:0] data_byte;
    } in_item_t;

    // Words produced by one byte: count is 0, 1 or 2 copies of word.
    typedef struct packed {
        logic [1:0]         count;
        logic signed [15:0] word;
    } conv_result_t;

    // Current configuration.
    typedef struct packed {
        logic [1:0] bytes_per_sample;
        logic [1:0] channel_count;
    } cfg_t;

endpackage

FILE: sv/pcm16_in_stage.sv
module pcm16_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  pcm16_pkg::in_item_t s_item,
    input  logic               advance_ok,
    output logic               item_valid,
    output pcm16_pkg::in_item_t item,
    output logic               advance
);

    logic                valid_reg;
    logic                valid_next;
    pcm16_pkg::in_item_t item_reg;

    // The held byte moves on when the result side can take its words.
    assign advance    = valid_reg && advance_ok;
    assign s_tready   = !valid_reg || advance_ok;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture on every input transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: sv/pcm16_convert.sv
`include "pcm_to_16bit_sample_converter_core_assert.svh"

module pcm16_convert
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  pcm16_pkg::in_item_t      item,
    input  pcm16_pkg::cfg_t          cfg,
    output pcm16_pkg::conv_result_t  result
);

    logic [2:0]         byte_position_reg;
    logic [2:0]         byte_position_next;
    logic [7:0]         held_low_byte_reg;
    logic [7:0]         held_low_byte_next;
    logic signed [15:0] held_left_sample_reg;
    logic signed [15:0] held_left_sample_next;

    logic               stereo;
    logic [2:0]         group_len;
    logic [2:0]         pos_raw;
    logic [2:0]         pos;
    logic [2:0]         pos_inc;
    logic [7:0]         b;
    logic signed [15:0] assembled;
    logic signed [16:0] pair_sum;
    logic signed [16:0] sum_adj;
    logic [1:0]         dup_count;

    assign stereo    = (cfg.channel_count == pcm16_pkg::CHAN_STEREO);
    assign b         = item.data_byte;
    assign assembled = {b, held_low_byte_reg};
    assign dup_count = stereo ? 2'd1 : 2'd2;

    // Group length and position of this byte within its group.
    always_comb
    begin
        case (cfg.bytes_per_sample)
            pcm16_pkg::BPS_8:  group_len = 3'd1;
            pcm16_pkg::BPS_16: group_len = 3'd2;
            pcm16_pkg::BPS_24: group_len = stereo ? 3'd6 : 3'd3;
            default:           group_len = 3'd1;
        endcase
        pos_raw = item.stream_start ? 3'd0 : byte_position_reg;
        pos     = (pos_raw >= group_len) ? 3'd0 : pos_raw;
        pos_inc = pos + 3'd1;
    end

    // Stereo 24-bit average, truncated toward zero.
    always_comb
    begin
        pair_sum = {held_left_sample_reg[15], held_left_sample_reg}
                 + {assembled[15], assembled};
        sum_adj  = pair_sum + {16'd0, pair_sum[16]};
    end

    // Result words and next state for the byte in hand.
    always_comb
    begin
        result                = '0;
        held_low_byte_next    = held_low_byte_reg;
        held_left_sample_next = held_left_sample_reg;
        byte_position_next    = (pos_inc >= group_len) ? 3'd0 : pos_inc;
        case (cfg.bytes_per_sample)
            pcm16_pkg::BPS_8:
            begin
                result.word  = {~b[7], b[6:0], 8'h00};
                result.count = dup_count;
            end
            pcm16_pkg::BPS_16:
            begin
                if (pos == 3'd0)
                begin
                    held_low_byte_next = b;
                end
                else
                begin
                    result.word  = assembled;
                    result.count = dup_count;
                end
            end
            pcm16_pkg::BPS_24:
            begin
                case (pos)
                    3'd1, 3'd4:
                    begin
                        held_low_byte_next = b;
                    end
                    3'd2:
                    begin
                        if (stereo)
                        begin
                            held_left_sample_next = assembled;
                        end
                        else
                        begin
                            result.word  = assembled;
                            result.count = 2'd1;
                        end
                    end
                    3'd5:
                    begin
                        result.word  = sum_adj[16:1];
                        result.count = 2'd1;
                    end
                    default:
                    begin
                        result.count = 2'd0;
                    end
                endcase
            end
            default:
            begin
                // Zero sample width drops the byte.
                byte_position_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= '0;
            held_low_byte_reg    <= '0;
            held_left_sample_reg <= '0;
        end
        else if (fire)
        begin
            byte_position_reg    <= byte_position_next;
            held_low_byte_reg    <= held_low_byte_next;
            held_left_sample_reg <= held_left_sample_next;
        end
    end

    // The position always lies inside the longest group.
    `PCM_ASSERT(a_pos_range, clk, rst_n, byte_position_reg < 3'd6,
        "byte position beyond the longest group")

endmodule

FILE: sv/pcm16_out_stage.sv
`include "pcm_to_16bit_sample_converter_core_assert.svh"

module pcm16_out_stage
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  pcm16_pkg::conv_result_t result,
    output logic                    load_ok,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [15:0]      m_tdata,
    output logic                    m_tlast
);

    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic signed [15:0] word_reg;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tdata  = word_reg;

    // A new result may enter when the register is empty or its last word leaves now.
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = result.count;
        end
        else if (m_tvalid && m_tready)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= result.word;
        end
    end

    // At most two copies of a word are ever pending.
    `PCM_ASSERT(a_cnt_max, clk, rst_n, cnt_reg != 2'd3,
        "output word count out of range")

    // The first of a pair moves on to the second copy of the same word.
    `PCM_ASSERT_IMPL(a_pair_step, clk, rst_n, (cnt_reg == 2'd2) && m_tready,
        (cnt_reg == 2'd1) && $stable(word_reg), "pair did not step to its last word")

    // No result is loaded over a pending pair.
    `PCM_ASSERT(a_no_overwrite, clk, rst_n, !(load && (cnt_reg == 2'd2)),
        "result loaded over a pending pair")

endmodule

FILE: sv/pcm_to_16bit_sample_converter_core.sv
// Converts the data bytes of a little-endian PCM stream into signed 16-bit
// words for a stereo serial audio transmitter. Bytes enter on the s_ side,
// words leave on the m_ side with tlast set on the final word caused by each
// byte. A byte is taken every cycle while the output is not stalled, as long as
// each byte makes at most one word; a byte that makes two words (mono 8-bit,
// high byte of mono 16-bit) occupies the single output register until its
// second word leaves. A word passes through the input register and then the
// output register after its byte's transfer. Write bytes_per_sample (index 0)
// and channel_count (index 1) only while no transfer is in flight; writes
// leave the byte assembly untouched.
module pcm_to_16bit_sample_converter_core
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data,
    // Input byte stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tuser,   // [0] stream_start
    // Output word stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic signed [15:0] m_tdata,   // [15:0] sample_word
    output logic               m_tlast    // last_of_run
);

    pcm16_pkg::cfg_t           cfg_reg;
    pcm16_pkg::in_item_t       s_item;
    pcm16_pkg::in_item_t       item;
    pcm16_pkg::conv_result_t   result;
    logic                      item_valid;
    logic                      advance;
    logic                      load_ok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_sample <= pcm16_pkg::BPS_RESET;
            cfg_reg.channel_count    <= pcm16_pkg::CHAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcm16_pkg::CFG_BYTES_PER_SAMPLE: cfg_reg.bytes_per_sample <= cfg_data;
                pcm16_pkg::CFG_CHANNEL_COUNT:    cfg_reg.channel_count    <= cfg_data;
                default:                         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign s_item.data_byte    = s_tdata;
    assign s_item.stream_start = s_tuser;

    pcm16_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance_ok (load_ok),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    pcm16_convert u_convert
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    pcm16_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && item_valid),
        .result   (result),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Channel codes outside the package that the block must treat as mono.
    localparam logic [1:0] CHAN_CODE0_MONO = 2'd0;
    localparam logic [1:0] CHAN_CODE3_MONO = 2'd3;

    // A directed row with this word count is checked against the predictor.
    localparam int USE_MODEL     = -1;
    localparam int RANDOM_ITEMS  = 1625;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;

    typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  bps;
        logic [1:0]  chan;
        logic [7:0]  data;
        logic        start;
        int          n_words;
        logic [15:0] word;
    } row_t;

    typedef struct {
        int          n_words;
        logic [15:0] word;
    } answer_t;

    typedef struct {
        logic [15:0] word;
        logic        last;
    } out_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [1:0]         cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [7:0] data_byte
    logic               s_tuser;   // [0] stream_start
    logic               m_tvalid;
    logic               m_tready;
    logic signed [15:0] m_tdata;   // [15:0] sample_word
    logic               m_tlast;   // last_of_run

    // Predictor copy of the configuration and the byte assembly state.
    logic [1:0]  bps_cfg;
    logic [1:0]  chan_cfg;
    logic [2:0]  byte_slot;
    logic [7:0]  low_hold;
    logic [15:0] left_hold;

    out_word_t fresh_words[$];
    out_word_t words_due[$];
    answer_t   row_answers[$];

    int  mismatch_count;
    int  quiet_cycles = 0;
    bit  tx_idle_on;
    bit  rx_idle_on;

    // Directed rows: extremes, restart, the 8-, 16- and 24-bit widths and every
    // channel code; the stale position and the disabled width follow in tail_rows.
    row_t directed_rows [25] = '{
        '{ROW_BYTE, 2'd0, 2'd0, 8'h00, 1'b1, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h80, 1'b0, 2,         16'h8000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'hFF, 1'b0, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h7F, 1'b0, 2,         16'h7FFF},
        '{ROW_BYTE, 2'd0, 2'd0, 8'hAB, 1'b0, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'hCD, 1'b1, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'hEF, 1'b0, 2,         16'hEFCD},
        '{ROW_CFG,  pcm16_pkg::BPS_8, pcm16_pkg::CHAN_STEREO,
          8'h00, 1'b0, 0, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h00, 1'b0, 1,         16'h8000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'hFF, 1'b0, 1,         16'h7F00},
        '{ROW_CFG,  pcm16_pkg::BPS_8, CHAN_CODE0_MONO,
          8'h00, 1'b0, 0, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h7F, 1'b0, 2,         16'hFF00},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h80, 1'b1, 2,         16'h0000},
        '{ROW_CFG,  pcm16_pkg::BPS_24, CHAN_CODE3_MONO,
          8'h00, 1'b0, 0, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h11, 1'b1, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h22, 1'b0, USE_MODEL, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h80, 1'b0, 1,         16'h8022},
        '{ROW_CFG,  pcm16_pkg::BPS_24, pcm16_pkg::CHAN_STEREO,
          8'h00, 1'b0, 0, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h00, 1'b1, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h00, 1'b0, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h80, 1'b0, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h55, 1'b0, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'hFF, 1'b0, 0,         16'h0000},
        // Full-scale left plus full-scale right averages to zero, not minus one.
        '{ROW_BYTE, 2'd0, 2'd0, 8'h7F, 1'b0, 1,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h12, 1'b0, USE_MODEL, 16'h0000}
    };

    // Rows after the table: a left-half byte of a stereo 24-bit frame, a switch
    // to 16-bit mono that leaves the position out of range, then width zero.
    row_t tail_rows [6] = '{
        '{ROW_BYTE, 2'd0, 2'd0, 8'h34, 1'b0, USE_MODEL, 16'h0000},
        '{ROW_CFG,  pcm16_pkg::BPS_16, pcm16_pkg::CHAN_RESET,
          8'h00, 1'b0, 0, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h10, 1'b0, 0,         16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h20, 1'b0, 2,         16'h2010},
        '{ROW_CFG,  pcm16_pkg::BPS_NONE, pcm16_pkg::CHAN_RESET,
          8'h00, 1'b0, 0, 16'h0000},
        '{ROW_BYTE, 2'd0, 2'd0, 8'h5A, 1'b1, 0,         16'h0000}
    };

    pcm_to_16bit_sample_converter_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap lengths: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_word(input logic [15:0] word, input logic twice);
        if (twice)
            fresh_words.push_back('{word, 1'b0});
        fresh_words.push_back('{word, 1'b1});
    endfunction

    // Predicts the words caused by one input byte and advances the assembly state.
    function automatic void convert_byte(input logic [7:0] b, input logic start);
        logic        stereo;
        int unsigned group_len;
        int unsigned slot;
        logic [15:0] word;
        int          avg;
        stereo = (chan_cfg == pcm16_pkg::CHAN_STEREO);
        if (bps_cfg == pcm16_pkg::BPS_NONE)
        begin
            byte_slot = '0;
            return;
        end
        if (bps_cfg == pcm16_pkg::BPS_8)
            group_len = 1;
        else if (bps_cfg == pcm16_pkg::BPS_16)
            group_len = 2;
        else
            group_len = stereo ? 6 : 3;
        slot = start ? 0 : byte_slot;
        if (slot >= group_len)
            slot = 0;
        byte_slot = (slot + 1 >= group_len) ? 3'd0 : 3'(slot + 1);
        word = {b, low_hold};
        case (bps_cfg)
            pcm16_pkg::BPS_8:
                queue_word({~b[7], b[6:0], 8'h00}, !stereo);
            pcm16_pkg::BPS_16:
                if (slot == 0)
                    low_hold = b;
                else
                    queue_word(word, !stereo);
            default:
                // The lowest byte of each 24-bit sample is dropped.
                case (slot)
                    1, 4:
                        low_hold = b;
                    2:
                        if (!stereo)
                            queue_word(word, 1'b0);
                        else
                            left_hold = word;
                    5:
                    begin
                        avg = (int'($signed(left_hold)) + int'($signed(word))) / 2;
                        queue_word(avg[15:0], 1'b0);
                    end
                    default:
                        ;
                endcase
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Offers one byte, waits for its transfer, then maybe idles.
    task automatic send_byte(input logic [7:0] data, input logic start,
                             input int n_words, input logic [15:0] word);
        int gap;
        row_answers.push_back('{n_words, word});
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        if (tx_idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = gap_len();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender until every pending word has arrived and the block settles.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on back-to-back edges.
    task automatic write_cfg(input logic [1:0] bps, input logic [1:0] chan);
        cfg_we    <= 1'b1;
        cfg_index <= pcm16_pkg::CFG_BYTES_PER_SAMPLE;
        cfg_data  <= bps;
        @(posedge clk);
        cfg_index <= pcm16_pkg::CFG_CHANNEL_COUNT;
        cfg_data  <= chan;
        @(posedge clk);
        cfg_we   <= 1'b0;
        bps_cfg  = bps;
        chan_cfg = chan;
    endtask

    task automatic run_row(input row_t row);
        if (row.kind == ROW_CFG)
        begin
            drain();
            write_cfg(row.bps, row.chan);
        end
        else
        begin
            send_byte(row.data, row.start, row.n_words, row.word);
        end
    endtask

    // Output side: random stalls of m_tready when enabled.
    initial
    begin : receiver
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    // Predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin : monitor
        answer_t   ans;
        out_word_t due;
        bit        moved;
        if (rst_n)
        begin
            moved = (s_tvalid && s_tready) || (m_tvalid && m_tready);
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (s_tvalid && s_tready)
            begin
                ans = row_answers.pop_front();
                fresh_words.delete();
                convert_byte(s_tdata, s_tuser);
                if (ans.n_words == USE_MODEL)
                begin
                    foreach (fresh_words[i])
                        words_due.push_back(fresh_words[i]);
                end
                else
                begin
                    for (int i = 0; i < ans.n_words; i++)
                        words_due.push_back('{ans.word, i == ans.n_words - 1});
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                begin
                    report_mismatch($sformatf("word %h with nothing pending", m_tdata));
                end
                else
                begin
                    due = words_due.pop_front();
                    if (m_tdata !== due.word)
                        report_mismatch($sformatf("sample_word %h, wanted %h",
                                                  m_tdata, due.word));
                    if (m_tlast !== due.last)
                        report_mismatch($sformatf("last_of_run %b, wanted %b on word %h",
                                                  m_tlast, due.last, due.word));
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, then random phases.
    initial
    begin : stimulus
        logic [1:0] bps;
        logic [1:0] chan;
        logic [7:0] data;
        logic       start;
        int         phase_len;
        int         counted;
        int         pick;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = pcm16_pkg::CFG_BYTES_PER_SAMPLE;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        bps_cfg        = pcm16_pkg::BPS_RESET;
        chan_cfg       = pcm16_pkg::CHAN_RESET;
        byte_slot      = '0;
        low_hold       = '0;
        left_hold      = '0;
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        counted        = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            run_row(directed_rows[i]);
        foreach (tail_rows[i])
            run_row(tail_rows[i]);

        // Random phases: each picks a setting, then streams bytes under it.
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            bps  = (pick == 0) ? pcm16_pkg::BPS_NONE : 2'($urandom_range(1, 3));
            pick = $urandom_range(0, 19);
            if (pick < 9)
                chan = pcm16_pkg::CHAN_STEREO;
            else if (pick < 16)
                chan = pcm16_pkg::CHAN_RESET;
            else if (pick < 18)
                chan = CHAN_CODE0_MONO;
            else
                chan = CHAN_CODE3_MONO;
            drain();
            write_cfg(bps, chan);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            phase_len  = (bps == pcm16_pkg::BPS_NONE) ? $urandom_range(5, 15)
                                                      : $urandom_range(30, 120);
            for (int i = 0; i < phase_len; i++)
            begin
                start = (i == 0 && $urandom_range(0, 1) == 1) || ($urandom_range(0, 15) == 0);
                pick  = $urandom_range(0, 7);
                if (pick == 0)
                    data = 8'h00;
                else if (pick == 1)
                    data = 8'hFF;
                else if (pick == 2)
                    data = {pick[0], 7'h7F} ^ 8'hFF;
                else
                    data = 8'($urandom);
                send_byte(data, start, USE_MODEL, '0);
                if (bps != pcm16_pkg::BPS_NONE)
                    counted++;
            end
        end

        // Wind down and judge the run.
        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        foreach (words_due[i])
            report_mismatch($sformatf("word %h never arrived", words_due[i].word));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/pcm16_pkg.sv
sv/pcm16_in_stage.sv
sv/pcm16_convert.sv
sv/pcm16_out_stage.sv
sv/pcm_to_16bit_sample_converter_core.sv
dv/tb.sv
